FILE: hdl/i2cbb_pkg.sv
// Types and constants shared by the I2C bit-bang master engine.
`timescale 1ns / 1ps
`default_nettype none

package i2cbb_pkg;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'd0,
        ST_START  = 4'd1,
        ST_STOP   = 4'd2,
        ST_WDATA  = 4'd3,
        ST_WHIGH  = 4'd4,
        ST_AREL   = 4'd5,
        ST_AHIGH  = 4'd6,
        ST_APOLL  = 4'd7,
        ST_TOSTOP = 4'd8,
        ST_AEND   = 4'd9,
        ST_RHIGH  = 4'd10,
        ST_RLOW   = 4'd11,
        ST_KSET   = 4'd12,
        ST_KHIGH  = 4'd13,
        ST_KLOW   = 4'd14,
        ST_KREL   = 4'd15
    } t_cmd_state;

    localparam logic [2:0] REQ_NONE  = 3'd0;
    localparam logic [2:0] REQ_START = 3'd1;
    localparam logic [2:0] REQ_STOP  = 3'd2;
    localparam logic [2:0] REQ_WRITE = 3'd3;
    localparam logic [2:0] REQ_READ  = 3'd4;

    localparam logic       CFG_HALF_PERIOD = 1'b0;
    localparam logic       CFG_POLL_LIMIT  = 1'b1;

    localparam logic [15:0] HALF_PERIOD_RST = 16'd5;
    localparam logic [7:0]  POLL_LIMIT_RST  = 8'd250;
    localparam logic [3:0]  BITS_PER_BYTE   = 4'd8;

    typedef struct packed {
        t_cmd_state  state;
        logic [1:0]  step;
        logic [3:0]  bits;
        logic [7:0]  shreg;
        logic [15:0] ticks;
        logic [7:0]  polls;
        logic        scl;
        logic        sda;
        logic        ack_fail;
        logic        ack_choice;
        logic [7:0]  rx_last;
    } t_eng_state;

    localparam t_eng_state ENG_RST = '{
        state: ST_IDLE, step: 2'd0, bits: 4'd0, shreg: 8'd0, ticks: 16'd0,
        polls: 8'd0, scl: 1'b1, sda: 1'b1, ack_fail: 1'b0, ack_choice: 1'b0,
        rx_last: 8'd0
    };

endpackage

`default_nettype wire

FILE: hdl/i2cbb_step.sv
// Next-state logic of the engine for one tick.
`timescale 1ns / 1ps
`default_nettype none

module i2cbb_step
    import i2cbb_pkg::*;
(
    input  wire t_eng_state  i_cur,
    input  wire logic [2:0]  i_req_type,
    input  wire logic [7:0]  i_tx_byte,
    input  wire logic        i_send_ack,
    input  wire logic        i_sda_in,
    input  wire logic [15:0] i_half_period,
    input  wire logic [7:0]  i_poll_limit,
    output t_eng_state       o_nxt,
    output logic             o_done
);

    function automatic t_eng_state f_enter(t_eng_state s, t_cmd_state st, logic [1:0] step);
        t_eng_state r;
        r       = s;
        r.state = st;
        r.step  = step;
        r.ticks = '0;
        case (st)
            ST_START: begin
                if (step == 2'd0) begin
                    r.sda = 1'b1;
                    r.scl = 1'b1;
                end else if (step == 2'd1) begin
                    r.sda = 1'b0;
                end else begin
                    r.scl = 1'b0;
                end
            end
            ST_STOP, ST_TOSTOP: begin
                if (step == 2'd0) begin
                    r.sda = 1'b0;
                end else if (step == 2'd1) begin
                    r.scl = 1'b1;
                end else begin
                    r.sda = 1'b1;
                end
            end
            ST_WDATA: begin
                r.scl = 1'b0;
                r.sda = s.shreg[7];
            end
            ST_WHIGH, ST_AHIGH, ST_KHIGH: r.scl = 1'b1;
            ST_AREL: begin
                r.scl = 1'b0;
                r.sda = 1'b1;
            end
            ST_AEND, ST_RLOW, ST_KLOW: r.scl = 1'b0;
            ST_RHIGH: begin
                r.scl = 1'b1;
                r.sda = 1'b1;
            end
            ST_KSET: r.sda = ~s.ack_choice;
            ST_KREL: r.sda = 1'b1;
            default: r = r;
        endcase
        return r;
    endfunction

    logic [15:0] hold;
    logic [15:0] tick_inc;
    logic [8:0]  poll_inc;
    logic [3:0]  bits_inc;
    t_eng_state  s;

    assign hold     = (i_half_period == 16'd0) ? 16'd1 : i_half_period;
    assign tick_inc = i_cur.ticks + 16'd1;
    assign poll_inc = {1'b0, i_cur.polls} + 9'd1;
    assign bits_inc = i_cur.bits + 4'd1;

    always_comb begin
        s      = i_cur;
        o_nxt  = i_cur;
        o_done = 1'b0;
        if (i_cur.state == ST_IDLE) begin
            case (i_req_type)
                REQ_START: o_nxt = f_enter(s, ST_START, 2'd0);
                REQ_STOP:  o_nxt = f_enter(s, ST_STOP, 2'd0);
                REQ_WRITE: begin
                    s.shreg    = i_tx_byte;
                    s.bits     = '0;
                    s.polls    = '0;
                    s.ack_fail = 1'b0;
                    o_nxt      = f_enter(s, ST_WDATA, 2'd0);
                end
                REQ_READ: begin
                    s.shreg      = '0;
                    s.bits       = '0;
                    s.ack_choice = i_send_ack;
                    o_nxt        = f_enter(s, ST_RHIGH, 2'd0);
                end
                default: o_nxt = i_cur;
            endcase
        end else if (tick_inc < hold) begin
            o_nxt.ticks = tick_inc;
        end else begin
            s.ticks = '0;
            o_nxt   = s;
            case (i_cur.state)
                ST_START, ST_STOP: begin
                    if (i_cur.step < 2'd2) begin
                        o_nxt = f_enter(s, i_cur.state, i_cur.step + 2'd1);
                    end else begin
                        o_nxt.state = ST_IDLE;
                        o_done      = 1'b1;
                    end
                end
                ST_TOSTOP: begin
                    if (i_cur.step < 2'd2) begin
                        o_nxt = f_enter(s, ST_TOSTOP, i_cur.step + 2'd1);
                    end else begin
                        o_nxt = f_enter(s, ST_AEND, 2'd0);
                    end
                end
                ST_WDATA: o_nxt = f_enter(s, ST_WHIGH, 2'd0);
                ST_WHIGH: begin
                    s.shreg = {i_cur.shreg[6:0], 1'b0};
                    s.bits  = bits_inc;
                    o_nxt   = f_enter(s, (bits_inc >= BITS_PER_BYTE) ? ST_AREL : ST_WDATA,
                                      2'd0);
                end
                ST_AREL: o_nxt = f_enter(s, ST_AHIGH, 2'd0);
                ST_AHIGH, ST_APOLL: begin
                    if (!i_sda_in) begin
                        o_nxt = f_enter(s, ST_AEND, 2'd0);
                    end else if (poll_inc > {1'b0, i_poll_limit}) begin
                        s.ack_fail = 1'b1;
                        o_nxt      = f_enter(s, ST_TOSTOP, 2'd0);
                    end else begin
                        s.polls = poll_inc[7:0];
                        o_nxt   = f_enter(s, ST_APOLL, 2'd0);
                    end
                end
                ST_AEND, ST_KREL: begin
                    o_nxt.state = ST_IDLE;
                    o_done      = 1'b1;
                end
                ST_RHIGH: begin
                    s.shreg = {i_cur.shreg[6:0], i_sda_in};
                    s.bits  = bits_inc;
                    o_nxt   = f_enter(s, ST_RLOW, 2'd0);
                end
                ST_RLOW: begin
                    if (i_cur.bits >= BITS_PER_BYTE) begin
                        s.rx_last = i_cur.shreg;
                        o_nxt     = f_enter(s, ST_KSET, 2'd0);
                    end else begin
                        o_nxt = f_enter(s, ST_RHIGH, 2'd0);
                    end
                end
                ST_KSET:  o_nxt = f_enter(s, ST_KHIGH, 2'd0);
                ST_KHIGH: o_nxt = f_enter(s, ST_KLOW, 2'd0);
                ST_KLOW: begin
                    if (i_cur.ack_choice) begin
                        o_nxt = f_enter(s, ST_KREL, 2'd0);
                    end else begin
                        o_nxt.state = ST_IDLE;
                        o_done      = 1'b1;
                    end
                end
                default: o_nxt.state = ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: hdl/i2c_bitbang_master_engine.sv
// Top level of the I2C bit-bang master engine: config, engine state, result register.
//
//  channel  | direction | handshake                      | payload
//  ---------+-----------+--------------------------------+---------------------------------
//  s_axis   | in        | s_axis_tvalid / s_axis_tready  | tdata: tx_byte, send_ack, sda_in
//           |           |                                | tuser: req_type
//  m_axis   | out       | m_axis_tvalid / m_axis_tready  | tdata: scl, sda, busy, done,
//           |           |                                | rx_byte, ack_error
//  cfg      | in        | i_cfg_valid / o_cfg_ready      | i_cfg_index, i_cfg_data
//
// Each input gives one output in the cycle after; one tick per cycle unless stalled.
// The engine state advances on each accepted input transaction only, through one pass of
// the next-state logic into the state and result registers.
// Synchronous active-low reset: engine idle, both lines released, config registers at defaults.
// A stalled output holds the result register and lowers s_axis_tready.
`timescale 1ns / 1ps
`default_nettype none

module i2c_bitbang_master_engine
    import i2cbb_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // tx_byte[7:0], send_ack[8], sda_in[9], zero
    input  wire logic [2:0]  s_axis_tuser,   // req_type[2:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // scl[0], sda[1], busy[2], done[3],
                                             // rx_byte[11:4], ack_error[12], zero
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    logic [15:0] r_half_period;
    logic [7:0]  r_poll_limit;
    t_eng_state  r_eng;
    t_eng_state  n_eng;
    logic        n_done;
    logic        r_out_valid;
    logic [15:0] r_out_data;
    logic        in_fire;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= HALF_PERIOD_RST;
            r_poll_limit  <= POLL_LIMIT_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_HALF_PERIOD) begin
                r_half_period <= i_cfg_data;
            end else begin
                r_poll_limit <= i_cfg_data[7:0];
            end
        end
    end

    i2cbb_step u_step (
        .i_cur         (r_eng),
        .i_req_type    (s_axis_tuser),
        .i_tx_byte     (s_axis_tdata[7:0]),
        .i_send_ack    (s_axis_tdata[8]),
        .i_sda_in      (s_axis_tdata[9]),
        .i_half_period (r_half_period),
        .i_poll_limit  (r_poll_limit),
        .o_nxt         (n_eng),
        .o_done        (n_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eng       <= ENG_RST;
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_eng       <= n_eng;
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out_data <= {3'b000, n_eng.ack_fail, n_eng.rx_last, n_done,
                           (n_eng.state != ST_IDLE), n_eng.sda, n_eng.scl};
        end
    end

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while result stalled");

    a_idle_no_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && r_eng.state == ST_IDLE && s_axis_tuser == REQ_NONE)
        |=> (r_eng.state == ST_IDLE))
        else $error("engine left idle without a command");

    a_idle_ticks_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_eng.state == ST_IDLE) |-> (r_eng.ticks == 16'd0))
        else $error("phase tick counter not cleared in idle");

    a_bits_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_eng.bits <= BITS_PER_BYTE)
        else $error("bit counter beyond one byte");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && n_done) |=> (r_eng.state == ST_IDLE && r_out_valid))
        else $error("completion reported while engine busy");

endmodule

`default_nettype wire

FILE: dv/tb_i2c_bitbang_master_engine.sv
// Self-checking testbench for the I2C bit-bang master engine: tick stream in, pin results out.
`timescale 1ns / 1ps

module tb_i2c_bitbang_master_engine;
    import i2cbb_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_OFF_CYCLES = 300;

    typedef struct packed {
        logic [2:0] req;
        logic       sda;
        logic       ack;
        logic [7:0] tx;
    } t_bus_tick;

    typedef struct packed {
        logic [2:0] zero;
        logic       aerr;
        logic [7:0] rx;
        logic       done;
        logic       busy;
        logic       sda;
        logic       scl;
    } t_pin_state;

    typedef enum int {LINE_RANDOM, LINE_LOW, LINE_HIGH} t_line_drive;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;     // tx_byte[7:0], send_ack[8], sda_in[9], zero
    logic [2:0]  s_axis_tuser = '0;     // req_type[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // scl[0], sda[1], busy[2], done[3], rx_byte[11:4],
                                        // ack_error[12], zero
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic [15:0] i_cfg_data = '0;

    t_bus_tick   tick_q[$];
    t_pin_state  pins_q[$];
    t_bus_tick   cur_tick;
    int          err_cnt = 0;
    int          cyc_cnt = 0;
    int          src_idle_pct = 33;
    int          sink_idle_pct = 75;
    logic        hold_off_armed = 1'b0;
    bit          hold_off_taken = 0;
    int          hold_off_left = 0;

    // engine shadow
    logic [15:0] half_period = HALF_PERIOD_RST;
    logic [7:0]  poll_limit = POLL_LIMIT_RST;
    t_cmd_state  eng_state = ST_IDLE;
    logic [1:0]  eng_step = '0;
    logic [3:0]  eng_bits = '0;
    logic [7:0]  eng_shreg = '0;
    logic [15:0] eng_ticks = '0;
    logic [7:0]  eng_polls = '0;
    logic        eng_scl = 1'b1;
    logic        eng_sda = 1'b1;
    logic        eng_ack_fail = 1'b0;
    logic        eng_ack_choice = 1'b0;
    logic [7:0]  eng_rx_last = '0;

    i2c_bitbang_master_engine u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic void enter_phase(t_cmd_state st, logic [1:0] ph);
        eng_state = st;
        eng_step  = ph;
        eng_ticks = '0;
        case (st)
            ST_START: begin
                if (ph == 2'd0) begin
                    eng_sda = 1'b1;
                    eng_scl = 1'b1;
                end else if (ph == 2'd1) begin
                    eng_sda = 1'b0;
                end else begin
                    eng_scl = 1'b0;
                end
            end
            ST_STOP, ST_TOSTOP: begin
                if (ph == 2'd0) eng_sda = 1'b0;
                else if (ph == 2'd1) eng_scl = 1'b1;
                else eng_sda = 1'b1;
            end
            ST_WDATA: begin
                eng_scl = 1'b0;
                eng_sda = eng_shreg[7];
            end
            ST_WHIGH, ST_AHIGH, ST_KHIGH: eng_scl = 1'b1;
            ST_AREL: begin
                eng_scl = 1'b0;
                eng_sda = 1'b1;
            end
            ST_AEND, ST_RLOW, ST_KLOW: eng_scl = 1'b0;
            ST_RHIGH: begin
                eng_scl = 1'b1;
                eng_sda = 1'b1;
            end
            ST_KSET: eng_sda = ~eng_ack_choice;
            ST_KREL: eng_sda = 1'b1;
            default: ;
        endcase
    endfunction

    function automatic bit end_of_phase(logic sda_smp);
        bit fin;
        fin = 0;
        case (eng_state)
            ST_START, ST_STOP: begin
                if (eng_step < 2'd2) begin
                    enter_phase(eng_state, eng_step + 2'd1);
                end else begin
                    eng_state = ST_IDLE;
                    fin = 1;
                end
            end
            ST_TOSTOP: begin
                if (eng_step < 2'd2) enter_phase(ST_TOSTOP, eng_step + 2'd1);
                else enter_phase(ST_AEND, 2'd0);
            end
            ST_WDATA: enter_phase(ST_WHIGH, 2'd0);
            ST_WHIGH: begin
                eng_shreg = eng_shreg << 1;
                eng_bits  = eng_bits + 4'd1;
                if (eng_bits >= BITS_PER_BYTE) enter_phase(ST_AREL, 2'd0);
                else enter_phase(ST_WDATA, 2'd0);
            end
            ST_AREL: enter_phase(ST_AHIGH, 2'd0);
            ST_AHIGH, ST_APOLL: begin
                if (!sda_smp) begin
                    enter_phase(ST_AEND, 2'd0);
                end else if ({1'b0, eng_polls} + 9'd1 > {1'b0, poll_limit}) begin
                    eng_ack_fail = 1'b1;
                    enter_phase(ST_TOSTOP, 2'd0);
                end else begin
                    eng_polls = eng_polls + 8'd1;
                    enter_phase(ST_APOLL, 2'd0);
                end
            end
            ST_AEND: begin
                eng_state = ST_IDLE;
                fin = 1;
            end
            ST_RHIGH: begin
                eng_shreg = {eng_shreg[6:0], sda_smp};
                eng_bits  = eng_bits + 4'd1;
                enter_phase(ST_RLOW, 2'd0);
            end
            ST_RLOW: begin
                if (eng_bits >= BITS_PER_BYTE) begin
                    eng_rx_last = eng_shreg;
                    enter_phase(ST_KSET, 2'd0);
                end else begin
                    enter_phase(ST_RHIGH, 2'd0);
                end
            end
            ST_KSET: enter_phase(ST_KHIGH, 2'd0);
            ST_KHIGH: enter_phase(ST_KLOW, 2'd0);
            ST_KLOW: begin
                if (eng_ack_choice) begin
                    enter_phase(ST_KREL, 2'd0);
                end else begin
                    eng_state = ST_IDLE;
                    fin = 1;
                end
            end
            ST_KREL: begin
                eng_state = ST_IDLE;
                fin = 1;
            end
            default: eng_state = ST_IDLE;
        endcase
        return fin;
    endfunction

    function automatic t_pin_state advance_tick(t_bus_tick tk);
        t_pin_state  res;
        logic [15:0] hold;
        bit          fin;
        hold = (half_period == 16'd0) ? 16'd1 : half_period;
        fin  = 0;
        if (eng_state == ST_IDLE) begin
            case (tk.req)
                REQ_START: enter_phase(ST_START, 2'd0);
                REQ_STOP:  enter_phase(ST_STOP, 2'd0);
                REQ_WRITE: begin
                    eng_shreg    = tk.tx;
                    eng_bits     = '0;
                    eng_polls    = '0;
                    eng_ack_fail = 1'b0;
                    enter_phase(ST_WDATA, 2'd0);
                end
                REQ_READ: begin
                    eng_shreg      = '0;
                    eng_bits       = '0;
                    eng_ack_choice = tk.ack;
                    enter_phase(ST_RHIGH, 2'd0);
                end
                default: ;
            endcase
        end else begin
            eng_ticks = eng_ticks + 16'd1;
            if (eng_ticks >= hold) begin
                eng_ticks = '0;
                fin = end_of_phase(tk.sda);
            end
        end
        res      = '0;
        res.scl  = eng_scl;
        res.sda  = eng_sda;
        res.busy = (eng_state != ST_IDLE);
        res.done = fin;
        res.rx   = eng_rx_last;
        res.aerr = eng_ack_fail;
        return res;
    endfunction

    function automatic int command_ticks(logic [2:0] req, bit timeout);
        int h;
        h = (half_period == 16'd0) ? 1 : int'(half_period);
        case (req)
            REQ_START, REQ_STOP: return 3 * h;
            REQ_WRITE: return timeout ? (23 + int'(poll_limit)) * h : 21 * h;
            REQ_READ: return 20 * h;
            default: return 0;
        endcase
    endfunction

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            err_cnt++;
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : drv
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) pins_q.push_back(advance_tick(cur_tick));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tick_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    cur_tick = tick_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {6'd0, cur_tick.sda, cur_tick.ack, cur_tick.tx};
                    s_axis_tuser  <= cur_tick.req;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : mon
        t_pin_state got;
        t_pin_state want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (pins_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected transaction, expected none actual %0h",
                             $time, m_axis_tdata);
                end else begin
                    want = pins_q.pop_front();
                    check_field("scl", want.scl, got.scl);
                    check_field("sda", want.sda, got.sda);
                    check_field("busy", want.busy, got.busy);
                    check_field("done", want.done, got.done);
                    check_field("rx_byte", want.rx, got.rx);
                    check_field("ack_error", want.aerr, got.aerr);
                end
            end
            if (hold_off_left != 0) begin
                hold_off_left--;
                m_axis_tready <= 1'b0;
            end else if (hold_off_armed && !hold_off_taken) begin
                hold_off_taken = 1;
                hold_off_left  = HOLD_OFF_CYCLES;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    task automatic queue_command(input logic [2:0] req, input logic [7:0] tx, input logic ack,
                                 input int n_after, input t_line_drive line, input bit noisy);
        t_bus_tick tk;
        for (int k = 0; k <= n_after; k++) begin
            if (k == 0) tk.req = req;
            else if (noisy && $urandom_range(99) < 15) tk.req = 3'($urandom_range(7));
            else tk.req = REQ_NONE;
            tk.tx  = (k == 0) ? tx : 8'($urandom);
            tk.ack = (k == 0) ? ack : 1'($urandom_range(1));
            case (line)
                LINE_LOW:  tk.sda = 1'b0;
                LINE_HIGH: tk.sda = 1'b1;
                default:   tk.sda = 1'($urandom_range(1));
            endcase
            tick_q.push_back(tk);
        end
    endtask

    task automatic wait_quiet();
        while (tick_q.size() != 0 || s_axis_tvalid || pins_q.size() != 0) @(posedge i_clk);
    endtask

    // drain the engine back to idle before touching the registers
    task automatic settle();
        wait_quiet();
        while (eng_state != ST_IDLE) begin
            queue_command(REQ_NONE, 8'd0, 1'b0, 4 * command_ticks(REQ_START, 0), LINE_RANDOM, 0);
            wait_quiet();
        end
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_HALF_PERIOD) half_period = val;
        else poll_limit = val[7:0];
    endtask

    task automatic random_traffic(input int n_items);
        int         stop_at;
        logic [2:0] req;
        bit         hi;
        stop_at = tick_q.size() + n_items;
        while (tick_q.size() < stop_at) begin
            if ($urandom_range(99) < 12) begin
                queue_command(3'($urandom_range(7)), 8'($urandom), 1'($urandom_range(1)),
                              $urandom_range(4), LINE_RANDOM, 1);
            end else begin
                req = 3'($urandom_range(REQ_START, REQ_READ));
                hi  = (req == REQ_WRITE) && (poll_limit <= 8'd8) && ($urandom_range(9) == 0);
                queue_command(req, 8'($urandom), 1'($urandom_range(1)),
                              command_ticks(req, hi) + $urandom_range(2),
                              hi ? LINE_HIGH : LINE_RANDOM, 1);
            end
        end
    endtask

    initial begin : timeout
        while (cyc_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cyc_cnt++;
        end
        $display("tb_i2c_bitbang_master_engine: FAIL");
        $finish;
    end

    initial begin : stim
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset register values
        queue_command(REQ_START, 8'h00, 1'b0, command_ticks(REQ_START, 0), LINE_RANDOM, 0);
        queue_command(REQ_STOP, 8'h00, 1'b0, command_ticks(REQ_STOP, 0), LINE_RANDOM, 0);
        settle();

        // zero poll limit, byte extremes, both acknowledge choices, unused codes
        write_reg(CFG_HALF_PERIOD, 16'd1);
        write_reg(CFG_POLL_LIMIT, 16'd0);
        queue_command(REQ_WRITE, 8'hFF, 1'b0, command_ticks(REQ_WRITE, 1), LINE_HIGH, 0);
        queue_command(REQ_WRITE, 8'h00, 1'b1, command_ticks(REQ_WRITE, 0), LINE_LOW, 0);
        queue_command(REQ_READ, 8'h00, 1'b1, command_ticks(REQ_READ, 0), LINE_HIGH, 0);
        queue_command(REQ_READ, 8'hFF, 1'b0, command_ticks(REQ_READ, 0), LINE_LOW, 0);
        queue_command(3'd5, 8'hAA, 1'b1, 0, LINE_RANDOM, 0);
        queue_command(3'd6, 8'h55, 1'b0, 0, LINE_RANDOM, 0);
        queue_command(3'd7, 8'hFF, 1'b1, 0, LINE_RANDOM, 0);
        // commands while busy and on the completing tick are dropped
        queue_command(REQ_START, 8'h00, 1'b0, 0, LINE_RANDOM, 0);
        queue_command(REQ_WRITE, 8'h5A, 1'b0, 1, LINE_RANDOM, 0);
        queue_command(REQ_READ, 8'h00, 1'b1, 0, LINE_RANDOM, 0);
        queue_command(REQ_STOP, 8'h00, 1'b0, command_ticks(REQ_STOP, 0), LINE_RANDOM, 0);
        settle();

        // zero half period, longest ACK poll
        write_reg(CFG_HALF_PERIOD, 16'd0);
        write_reg(CFG_POLL_LIMIT, 16'd255);
        queue_command(REQ_WRITE, 8'h81, 1'b0, command_ticks(REQ_WRITE, 1), LINE_HIGH, 0);
        queue_command(REQ_READ, 8'h00, 1'b1, command_ticks(REQ_READ, 0), LINE_RANDOM, 0);
        settle();

        // longest half period; shorten it again part way through the start
        write_reg(CFG_HALF_PERIOD, 16'hFFFF);
        queue_command(REQ_START, 8'h00, 1'b0, 120, LINE_RANDOM, 0);
        wait_quiet();
        write_reg(CFG_HALF_PERIOD, 16'd1);
        settle();

        write_reg(CFG_HALF_PERIOD, 16'd2);
        write_reg(CFG_POLL_LIMIT, 16'd3);
        random_traffic(190);
        settle();

        src_idle_pct  = 75;
        sink_idle_pct = 33;
        write_reg(CFG_HALF_PERIOD, 16'd1);
        write_reg(CFG_POLL_LIMIT, 16'd1);
        random_traffic(190);
        hold_off_armed <= 1'b1;
        settle();

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        write_reg(CFG_HALF_PERIOD, 16'd3);
        write_reg(CFG_POLL_LIMIT, 16'd255);
        random_traffic(190);
        settle();

        repeat (10) @(posedge i_clk);
        if (err_cnt == 0 && pins_q.size() == 0) begin
            $display("tb_i2c_bitbang_master_engine: PASS");
        end else begin
            $display("tb_i2c_bitbang_master_engine: FAIL");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/i2cbb_pkg.sv
hdl/i2cbb_step.sv
hdl/i2c_bitbang_master_engine.sv
dv/tb_i2c_bitbang_master_engine.sv
